### hw/rtl/mrf_pkg.sv
// ----------------------------------------------------------------------------
// mrf_pkg
// Types, codes and the crc step shared by the response framer modules.
// ----------------------------------------------------------------------------
package mrf_pkg;

	localparam int MAX_FRAME_BYTES = 256;

	// item kinds
	localparam logic [1:0] KIND_START = 2'd0;
	localparam logic [1:0] KIND_BYTE  = 2'd1;
	localparam logic [1:0] KIND_GAP   = 2'd2;

	// end causes
	localparam logic [1:0] CAUSE_NONE   = 2'd0;
	localparam logic [1:0] CAUSE_LIMIT  = 2'd1;
	localparam logic [1:0] CAUSE_BUDGET = 2'd2;
	localparam logic [1:0] CAUSE_GAP    = 2'd3;

	// configuration register indexes
	localparam int CFG_INDEX_W = 1;
	localparam logic [CFG_INDEX_W-1:0] CFG_SLAVE_ADDRESS = 1'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_LENGTH_LIMIT  = 1'd1;
	localparam int CFG_DATA_W = 9;

	localparam logic [7:0]  SLAVE_ADDRESS_RESET = 8'h98;
	localparam logic [8:0]  LENGTH_LIMIT_RESET  = 9'd256;

	// function codes
	localparam logic [7:0] FC_READ_HOLDING = 8'h03;
	localparam logic [7:0] FC_READ_INPUT   = 8'h04;
	localparam logic [7:0] FC_WRITE_SINGLE = 8'h06;

	localparam logic [10:0] BUDGET_BONUS   = 11'd10;
	localparam logic [8:0]  BYTE_COUNT_POS = 9'd2;
	localparam logic [8:0]  MIN_CRC_LENGTH = 9'd4;

	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'hA001;

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_HUNT,
		PH_WAIT,
		PH_COLLECT
	} phase_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] data_byte;
		logic [9:0] budget;
	} item_t;

	typedef struct packed {
		logic [7:0] frame_byte;
		logic [7:0] position;
		logic       byte_valid;
		logic       frame_end;
		logic [1:0] end_cause;
		logic [8:0] frame_length;
		logic       crc_ok;
	} result_t;

	// results handed from the framer to the result queue in one cycle
	typedef struct packed {
		logic [1:0] cnt;
		result_t    first;
		result_t    second;
	} push_t;

	// one byte of the reflected modbus crc
	function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int i = 0; i < 8; i++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

	localparam logic [15:0] CRC_ADDR_RESET = crc_feed(CRC_INIT, SLAVE_ADDRESS_RESET);

endpackage

### hw/rtl/mrf_res_fifo.sv
// ----------------------------------------------------------------------------
// mrf_res_fifo
// Small result queue: takes up to two results a cycle, hands out one.
// ----------------------------------------------------------------------------
module mrf_res_fifo (
	input  logic            clk,
	input  logic            arst_n,
	input  mrf_pkg::push_t  push,
	output logic            room2,
	output logic            result_valid,
	input  logic            result_ready,
	output mrf_pkg::result_t result
);
	import mrf_pkg::*;

	localparam int DEPTH = 4;
	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	result_t            mem_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;
	logic [PTR_W-1:0]   wr_next;
	logic               pop;

	assign wr_next      = wr_ptr_q + PTR_W'(1);
	assign pop          = result_valid && result_ready;
	assign result_valid = (count_q != '0);
	assign result       = mem_q[rd_ptr_q];
	assign room2        = (count_q <= CNT_W'(DEPTH - 2));

	always_ff @(posedge clk) begin
		if (push.cnt != 2'd0) begin
			mem_q[wr_ptr_q] <= push.first;
		end
		if (push.cnt == 2'd2) begin
			mem_q[wr_next] <= push.second;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + PTR_W'(push.cnt);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			count_q <= count_q + CNT_W'(push.cnt) - CNT_W'(pop);
		end
	end

endmodule

### hw/rtl/mrf_core.sv
// ----------------------------------------------------------------------------
// mrf_core
// Input register, configuration registers and the framing state machine.
// ----------------------------------------------------------------------------
module mrf_core (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 item_valid,
	output logic                                 item_ready,
	input  mrf_pkg::item_t                       item,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [mrf_pkg::CFG_INDEX_W-1:0]      cfg_index,
	input  logic [mrf_pkg::CFG_DATA_W-1:0]       cfg_data,
	input  logic                                 room2,
	output mrf_pkg::push_t                       push
);
	import mrf_pkg::*;

	item_t        item_s1;
	logic         valid_s1;
	logic         advance;

	logic [7:0]   slave_addr_q;
	logic [8:0]   length_limit_q;
	logic [15:0]  crc_addr_q;

	phase_t       phase_q, phase_d;
	logic [10:0]  budget_q, budget_d;
	logic [8:0]   count_q, count_d;
	logic         fc34_q, fc34_d;
	logic [15:0]  crc_q, crc_d;

	logic [8:0]   limit;
	logic [10:0]  bud_dec;
	logic [10:0]  bud_add;
	logic [15:0]  crc_byte;
	logic [15:0]  crc_code;
	logic [8:0]   count_inc;
	logic         is_code;
	logic         check_now;
	logic         check_next;
	logic [7:0]   data;

	assign cfg_ready  = 1'b1;
	assign advance    = valid_s1 && room2;
	assign item_ready = !valid_s1 || room2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_ready) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_ready && item_valid) begin
			item_s1 <= item;
		end
	end

	// the address byte's crc is kept ready so code acceptance needs one crc step
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slave_addr_q   <= SLAVE_ADDRESS_RESET;
			length_limit_q <= LENGTH_LIMIT_RESET;
			crc_addr_q     <= CRC_ADDR_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_SLAVE_ADDRESS: begin
					slave_addr_q <= cfg_data[7:0];
					crc_addr_q   <= crc_feed(CRC_INIT, cfg_data[7:0]);
				end
				CFG_LENGTH_LIMIT: begin
					length_limit_q <= cfg_data;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			budget_q <= '0;
			count_q  <= '0;
			fc34_q   <= 1'b0;
			crc_q    <= CRC_INIT;
		end else begin
			phase_q  <= phase_d;
			budget_q <= budget_d;
			count_q  <= count_d;
			fc34_q   <= fc34_d;
			crc_q    <= crc_d;
		end
	end

	always_comb begin
		limit = length_limit_q;
		if (length_limit_q == 9'd0) begin
			limit = 9'd1;
		end
		if (32'(length_limit_q) > MAX_FRAME_BYTES) begin
			limit = 9'(MAX_FRAME_BYTES);
		end
	end

	always_comb begin
		data       = item_s1.data_byte;
		bud_dec    = (budget_q != '0) ? budget_q - 11'd1 : budget_q;
		bud_add    = bud_dec + ((count_q == BYTE_COUNT_POS && fc34_q) ?
		             {3'b000, data} : 11'd0);
		crc_byte   = crc_feed(crc_q, data);
		crc_code   = crc_feed(crc_addr_q, data);
		count_inc  = count_q + 9'd1;
		is_code    = data inside {FC_READ_HOLDING, FC_READ_INPUT, FC_WRITE_SINGLE};
		check_now  = (count_q >= MIN_CRC_LENGTH) && (crc_q == '0);
		check_next = (count_inc >= MIN_CRC_LENGTH) && (crc_byte == '0);

		phase_d  = phase_q;
		budget_d = budget_q;
		count_d  = count_q;
		fc34_d   = fc34_q;
		crc_d    = crc_q;
		push     = '0;

		if (advance) begin
			case (item_s1.kind)
				KIND_START: begin
					count_d  = '0;
					fc34_d   = 1'b0;
					crc_d    = CRC_INIT;
					budget_d = {1'b0, item_s1.budget};
					if (item_s1.budget == '0) begin
						phase_d                = PH_IDLE;
						push.cnt               = 2'd1;
						push.first.frame_end   = 1'b1;
						push.first.end_cause   = CAUSE_BUDGET;
					end else begin
						phase_d = PH_HUNT;
					end
				end
				KIND_GAP: begin
					if (phase_q != PH_IDLE) begin
						phase_d                 = PH_IDLE;
						push.cnt                = 2'd1;
						push.first.frame_end    = 1'b1;
						push.first.end_cause    = CAUSE_GAP;
						push.first.frame_length = count_q;
						push.first.crc_ok       = check_now;
					end
				end
				KIND_BYTE: begin
					case (phase_q)
						PH_HUNT, PH_WAIT: begin
							budget_d = bud_dec;
							if (phase_q == PH_WAIT && is_code) begin
								fc34_d   = (data == FC_READ_HOLDING) || (data == FC_READ_INPUT);
								count_d  = 9'd2;
								crc_d    = crc_code;
								budget_d = bud_dec + BUDGET_BONUS;
								phase_d  = PH_COLLECT;
								push.cnt = 2'd2;
								push.first.frame_byte  = slave_addr_q;
								push.first.byte_valid  = 1'b1;
								push.second.frame_byte = data;
								push.second.position   = 8'd1;
								push.second.byte_valid = 1'b1;
							end else begin
								if (data == slave_addr_q) begin
									phase_d = PH_WAIT;
								end else if (phase_q == PH_WAIT) begin
									phase_d = PH_HUNT;
								end
								if (bud_dec == '0) begin
									phase_d                 = PH_IDLE;
									push.cnt                = 2'd1;
									push.first.frame_end    = 1'b1;
									push.first.end_cause    = CAUSE_BUDGET;
									push.first.frame_length = count_q;
									push.first.crc_ok       = check_now;
								end
							end
						end
						PH_COLLECT: begin
							budget_d = bud_add;
							crc_d    = crc_byte;
							count_d  = count_inc;
							push.cnt = 2'd1;
							push.first.frame_byte = data;
							push.first.position   = count_q[7:0];
							push.first.byte_valid = 1'b1;
							// the length limit wins over a spent budget
							if (count_inc >= limit || bud_add == '0) begin
								phase_d                 = PH_IDLE;
								push.first.frame_end    = 1'b1;
								push.first.end_cause    = (count_inc >= limit) ?
								                          CAUSE_LIMIT : CAUSE_BUDGET;
								push.first.frame_length = count_inc;
								push.first.crc_ok       = check_next;
							end
						end
						default: ;
					endcase
				end
				default: ;
			endcase
		end
	end

endmodule

### hw/rtl/modbus_response_framer_top.sv
// ----------------------------------------------------------------------------
// modbus_response_framer_top
// Modbus RTU response framer: address/code hunt, budgeted collect, crc check.
// ----------------------------------------------------------------------------
// One item is taken every cycle while the result queue has room for two
// results. An item is held in the input register, where the framing state
// machine and two eight-step crc byte updates decide its results, and its
// results are then written into the result queue. An accepted function code
// yields two results (address and code) that leave one after the other;
// every other item yields at most one. The four-entry result queue sets
// the stall point: the input stalls only when three or more are held back.
module modbus_response_framer_top (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             item_valid,
	output logic                             item_ready,
	input  mrf_pkg::item_t                   item,
	output logic                             result_valid,
	input  logic                             result_ready,
	output mrf_pkg::result_t                 result,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [mrf_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  logic [mrf_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import mrf_pkg::*;

	push_t push;
	logic  room2;

	mrf_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.item       (item),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.room2      (room2),
		.push       (push)
	);

	mrf_res_fifo u_res_fifo (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.room2        (room2),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

endmodule

### hw/rtl/mrf_checker.sv
// ----------------------------------------------------------------------------
// mrf_props
// Port-level checks on the framer's result items.
// ----------------------------------------------------------------------------
module mrf_props (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             result_valid,
	input  logic             result_ready,
	input  mrf_pkg::result_t result
);
	import mrf_pkg::*;

	// a stalled item stays put
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result))
		else $error("result item changed while stalled");

	// an item without a byte only ever closes a session
	a_empty_is_end: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.byte_valid |-> result.frame_end)
		else $error("empty item that does not end the session");

	a_mid_fields: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.frame_end |->
		result.end_cause == CAUSE_NONE && result.frame_length == 9'd0 && !result.crc_ok)
		else $error("end fields set on a mid-frame item");

	a_crc_len: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.crc_ok |-> result.frame_length >= MIN_CRC_LENGTH)
		else $error("crc ok on a frame shorter than four bytes");

	// the closing byte is the last stored one
	a_last_pos: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.byte_valid && result.frame_end |->
		result.frame_length == {1'b0, result.position} + 9'd1)
		else $error("frame length does not follow the closing byte");

endmodule

bind modbus_response_framer_top mrf_props u_mrf_props (
	.clk          (clk),
	.arst_n       (arst_n),
	.result_valid (result_valid),
	.result_ready (result_ready),
	.result       (result)
);

### verif/mrf_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mrf_checker
// Follows the framer's item, result and register channels. Every accepted
// item updates a private copy of the framing state and queues the frames
// results it must cause; every delivered result is compared field by field
// with the oldest one waiting.
// ----------------------------------------------------------------------------
package mrf_tb_pkg;

	// one byte of the reflected modbus crc, lsb first
	function automatic logic [15:0] crc16_next(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = {crc[15:8], crc[7:0] ^ b};
		repeat (8) begin
			c = {1'b0, c[15:1]} ^ (c[0] ? mrf_pkg::CRC_POLY : 16'h0000);
		end
		return c;
	endfunction

endpackage

module mrf_checker (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             item_valid,
	input  logic                             item_ready,
	input  mrf_pkg::item_t                   item,
	input  logic                             result_valid,
	input  logic                             result_ready,
	input  mrf_pkg::result_t                 result,
	input  logic                             cfg_valid,
	input  logic                             cfg_ready,
	input  logic [mrf_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  logic [mrf_pkg::CFG_DATA_W-1:0]   cfg_data,
	output int                               outstanding,
	output int                               error_count
);

	import mrf_pkg::*;
	import mrf_tb_pkg::*;

	logic [7:0]  addr_reg;
	logic [8:0]  limit_reg;
	phase_t      phase;
	logic [10:0] budget_left;
	logic [8:0]  stored;
	logic [7:0]  fcode;
	logic [15:0] crc;
	result_t     frame_q[$];
	result_t     want;

	function automatic result_t make_result(input logic [7:0] b, input logic [7:0] pos,
			input logic v, input logic e, input logic [1:0] cause, input logic [8:0] len,
			input logic ok);
		result_t r;
		r.frame_byte   = b;
		r.position     = pos;
		r.byte_valid   = v;
		r.frame_end    = e;
		r.end_cause    = cause;
		r.frame_length = len;
		r.crc_ok       = ok;
		return r;
	endfunction

	function automatic logic crc_good();
		return (stored >= MIN_CRC_LENGTH) && (crc == 16'h0000);
	endfunction

	task automatic predict_frame(input item_t it);
		int         lim;
		logic       is_read;
		logic       searching;
		logic [7:0] pos;
		logic [7:0] d;
		lim = (limit_reg == 9'd0) ? 1 :
			(limit_reg > MAX_FRAME_BYTES) ? MAX_FRAME_BYTES : int'(limit_reg);
		is_read = (fcode == FC_READ_HOLDING) || (fcode == FC_READ_INPUT);
		searching = (phase == PH_HUNT) || (phase == PH_WAIT);
		d = it.data_byte;
		if (it.kind == KIND_START) begin
			stored = '0;
			fcode = '0;
			crc = CRC_INIT;
			budget_left = {1'b0, it.budget};
			if (it.budget == '0) begin
				phase = PH_IDLE;
				frame_q.push_back(make_result('0, '0, 1'b0, 1'b1, CAUSE_BUDGET, '0, 1'b0));
			end else begin
				phase = PH_HUNT;
			end
		end else if (phase == PH_IDLE || !(it.kind == KIND_BYTE || it.kind == KIND_GAP)) begin
			// nothing open, or a kind the block does not know
		end else if (it.kind == KIND_GAP) begin
			phase = PH_IDLE;
			frame_q.push_back(make_result('0, '0, 1'b0, 1'b1, CAUSE_GAP, stored, crc_good()));
		end else begin
			if (budget_left != '0) begin
				budget_left = budget_left - 11'd1;
			end
			case (phase)
			PH_HUNT: begin
				if (d == addr_reg) begin
					phase = PH_WAIT;
				end
			end
			PH_WAIT: begin
				if (d == FC_READ_HOLDING || d == FC_READ_INPUT || d == FC_WRITE_SINGLE) begin
					fcode = d;
					crc = crc16_next(crc16_next(CRC_INIT, addr_reg), d);
					stored = 9'd2;
					budget_left = budget_left + BUDGET_BONUS;
					phase = PH_COLLECT;
					frame_q.push_back(make_result(addr_reg, 8'd0, 1'b1, 1'b0, CAUSE_NONE, '0, 1'b0));
					frame_q.push_back(make_result(d, 8'd1, 1'b1, 1'b0, CAUSE_NONE, '0, 1'b0));
				end else if (d != addr_reg) begin
					phase = PH_HUNT;
				end
			end
			default: begin
				// byte count of a read response extends the budget
				if (stored == BYTE_COUNT_POS && is_read) begin
					budget_left = budget_left + {3'b000, d};
				end
				pos = stored[7:0];
				crc = crc16_next(crc, d);
				stored = stored + 9'd1;
				if (stored >= lim) begin
					phase = PH_IDLE;
					frame_q.push_back(make_result(d, pos, 1'b1, 1'b1, CAUSE_LIMIT, stored,
						crc_good()));
				end else if (budget_left == '0) begin
					phase = PH_IDLE;
					frame_q.push_back(make_result(d, pos, 1'b1, 1'b1, CAUSE_BUDGET, stored,
						crc_good()));
				end else begin
					frame_q.push_back(make_result(d, pos, 1'b1, 1'b0, CAUSE_NONE, '0, 1'b0));
				end
			end
			endcase
			if (searching && phase != PH_COLLECT && budget_left == '0) begin
				phase = PH_IDLE;
				frame_q.push_back(make_result('0, '0, 1'b0, 1'b1, CAUSE_BUDGET, stored,
					crc_good()));
			end
		end
	endtask

	task automatic check_field(input string name, input logic [15:0] exp_v,
			input logic [15:0] act_v);
		if (exp_v !== act_v) begin
			$error("%s mismatch: expected %0d, actual %0d", name, exp_v, act_v);
			error_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_reg = SLAVE_ADDRESS_RESET;
			limit_reg = LENGTH_LIMIT_RESET;
			phase = PH_IDLE;
			budget_left = '0;
			stored = '0;
			fcode = '0;
			crc = CRC_INIT;
			frame_q.delete();
			outstanding = 0;
			error_count = 0;
		end else begin
			if (result_valid && result_ready) begin
				if (frame_q.size() == 0) begin
					$error("result item with none expected: frame_byte %0d position %0d",
						result.frame_byte, result.position);
					error_count++;
				end else begin
					want = frame_q.pop_front();
					check_field("frame_byte", 16'(want.frame_byte), 16'(result.frame_byte));
					check_field("position", 16'(want.position), 16'(result.position));
					check_field("byte_valid", 16'(want.byte_valid), 16'(result.byte_valid));
					check_field("frame_end", 16'(want.frame_end), 16'(result.frame_end));
					check_field("end_cause", 16'(want.end_cause), 16'(result.end_cause));
					check_field("frame_length", 16'(want.frame_length),
						16'(result.frame_length));
					check_field("crc_ok", 16'(want.crc_ok), 16'(result.crc_ok));
				end
			end
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == CFG_SLAVE_ADDRESS) begin
					addr_reg = cfg_data[7:0];
				end else begin
					limit_reg = cfg_data;
				end
			end
			if (item_valid && item_ready) begin
				predict_frame(item);
			end
			outstanding = frame_q.size();
		end
	end

endmodule

### verif/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Drives the response framer with directed corner items and random response
// frames over several register settings, with random idling on both sides.
// ----------------------------------------------------------------------------
module tb_top;

	import mrf_pkg::*;
	import mrf_tb_pkg::*;

	localparam logic [1:0] KIND_SPARE     = 2'd3;
	localparam int         WATCHDOG_LIMIT = 1000;
	localparam int         DRAIN_CYCLES   = 8;

	logic                   clk;
	logic                   arst_n;
	logic                   item_valid;
	logic                   item_ready;
	item_t                  item;
	logic                   result_valid;
	logic                   result_ready;
	result_t                result;
	logic                   cfg_valid;
	logic                   cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;
	int                     outstanding;
	int                     error_count;

	bit         calm;
	int         sent;
	int         stall_cycles = 0;
	logic [7:0] cur_addr;

	modbus_response_framer_top dut (.*);

	mrf_checker chk (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		result_ready <= 1'b0;
		forever begin
			@(posedge clk);
			result_ready <= calm || ($urandom_range(99) >= 26);
		end
	end

	// ends the run when no channel moves for too long
	always @(posedge clk) begin
		if ((item_valid && item_ready) || (result_valid && result_ready) ||
				(cfg_valid && cfg_ready)) begin
			stall_cycles <= 0;
		end else if (stall_cycles == WATCHDOG_LIMIT) begin
			$display("Verification failed");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	task automatic send_item(input logic [1:0] k, input logic [7:0] d, input logic [9:0] b);
		if (!calm && $urandom_range(99) < 26) begin
			item_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < 26);
		end
		item_valid <= 1'b1;
		item <= {k, d, b};
		do @(posedge clk); while (!item_ready);
		sent++;
	endtask

	task automatic send_byte(input logic [7:0] d);
		send_item(KIND_BYTE, d, 10'($urandom));
	endtask

	task automatic write_cfg(input logic [CFG_INDEX_W-1:0] idx, input logic [8:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_regs(input logic [7:0] addr, input logic [8:0] lim);
		write_cfg(CFG_SLAVE_ADDRESS, {1'b0, addr});
		write_cfg(CFG_LENGTH_LIMIT, lim);
		cur_addr = addr;
	endtask

	// wait until every expected result is out, then let the pipeline settle
	task automatic drain_frames();
		item_valid <= 1'b0;
		do @(negedge clk); while (outstanding != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic send_frame();
		logic [15:0] crc;
		logic [7:0]  fc;
		logic [7:0]  d;
		int          n;
		if ($urandom_range(99) < 8) begin
			send_item(KIND_START, 8'($urandom), 10'($urandom_range(6)));
		end else begin
			send_item(KIND_START, 8'($urandom), 10'($urandom_range(1023, 8)));
		end
		repeat ($urandom_range(2)) send_byte(8'($urandom));
		if ($urandom_range(9) != 0) begin
			send_byte(cur_addr);
		end
		if ($urandom_range(9) == 0) begin
			send_byte(cur_addr);
		end
		case ($urandom_range(6))
		0: fc = 8'($urandom);
		1, 2: fc = FC_READ_HOLDING;
		3, 4: fc = FC_READ_INPUT;
		default: fc = FC_WRITE_SINGLE;
		endcase
		send_byte(fc);
		crc = crc16_next(crc16_next(CRC_INIT, cur_addr), fc);
		if (fc == FC_READ_HOLDING || fc == FC_READ_INPUT) begin
			n = ($urandom_range(19) == 0) ? $urandom_range(255) : $urandom_range(12);
			send_byte(n[7:0]);
			crc = crc16_next(crc, n[7:0]);
		end else begin
			n = 4;
		end
		repeat (n) begin
			d = 8'($urandom);
			send_byte(d);
			crc = crc16_next(crc, d);
		end
		// now and then a broken check value
		if ($urandom_range(6) == 0) begin
			crc = crc ^ (16'd1 << $urandom_range(15));
		end
		send_byte(crc[7:0]);
		send_byte(crc[15:8]);
		case ($urandom_range(9))
		0, 1: ; // left open, the next start drops it
		2, 3: begin
			repeat ($urandom_range(3, 1)) send_byte(8'($urandom));
			send_item(KIND_GAP, 8'($urandom), 10'($urandom));
		end
		4: begin
			send_item(KIND_SPARE, 8'($urandom), 10'($urandom));
			send_item(KIND_GAP, 8'($urandom), 10'($urandom));
		end
		default: send_item(KIND_GAP, 8'($urandom), 10'($urandom));
		endcase
	endtask

	task automatic run_frames(input int target);
		while (sent < target) begin
			if ($urandom_range(9) == 0) begin
				send_item(2'($urandom_range(3)), 8'($urandom), 10'($urandom));
			end else begin
				send_frame();
			end
		end
	endtask

	initial begin
		arst_n <= 1'b0;
		item_valid <= 1'b0;
		item <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		calm = 1'b0;
		sent = 0;
		cur_addr = SLAVE_ADDRESS_RESET;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		set_regs(SLAVE_ADDRESS_RESET, LENGTH_LIMIT_RESET);
		// items outside a session and an unknown kind
		send_byte(8'h55);
		send_item(KIND_GAP, 8'h00, 10'h000);
		send_item(KIND_SPARE, 8'hFF, 10'h3FF);
		// zero budget ends at once
		send_item(KIND_START, 8'hFF, 10'd0);
		// repeated address waits, other byte goes back to hunting
		send_item(KIND_START, 8'h00, 10'h3FF);
		send_byte(cur_addr);
		send_byte(cur_addr);
		send_byte(8'h05);
		send_byte(cur_addr);
		send_byte(FC_READ_HOLDING);
		send_byte(8'h00);
		send_byte(8'hFF);
		send_item(KIND_GAP, 8'hAA, 10'h155);
		// budget spent while hunting
		send_item(KIND_START, 8'h00, 10'd1);
		send_byte(8'h00);
		// restart drops the open session
		send_item(KIND_START, 8'h00, 10'd20);
		send_byte(cur_addr);
		send_byte(FC_READ_INPUT);
		send_item(KIND_START, 8'h00, 10'd5);
		send_item(KIND_GAP, 8'h00, 10'h000);
		drain_frames();

		// length limit and spent budget on the same byte
		set_regs(SLAVE_ADDRESS_RESET, 9'd12);
		send_item(KIND_START, 8'h00, 10'd2);
		send_byte(cur_addr);
		send_byte(FC_WRITE_SINGLE);
		repeat (10) send_byte(8'($urandom));
		drain_frames();

		set_regs(8'h00, 9'd0);
		run_frames(200);
		drain_frames();

		set_regs(8'hFF, 9'd511);
		calm = 1'b1;
		run_frames(370);
		calm = 1'b0;
		drain_frames();

		set_regs(8'($urandom), 9'($urandom_range(30, 4)));
		run_frames(540);
		drain_frames();

		set_regs(8'($urandom), LENGTH_LIMIT_RESET);
		run_frames(740);
		drain_frames();

		@(negedge clk);
		if (error_count == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule

### modbus_response_framer_top.f
hw/rtl/mrf_pkg.sv
hw/rtl/mrf_res_fifo.sv
hw/rtl/mrf_core.sv
hw/rtl/modbus_response_framer_top.sv
hw/rtl/mrf_checker.sv
verif/mrf_checker.sv
verif/tb_top.sv
